// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the search block's RTL.
// Plain text only; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DCES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define DCES_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dces_pkg.sv =====
// Package for the DAC code search block: codes, item structs, settle table.
// No dependencies; used by the interfaces and all RTL modules.
package dces_pkg;

    localparam int CMD_BITS      = 2;
    localparam int FIELD_CODE    = 12;
    localparam int OHMS_BITS     = 24;
    localparam int ACT_BITS      = 2;
    localparam int SETTLE_BITS   = 14;
    localparam int CODE_BITS_MAX = 16;

    localparam logic [CMD_BITS-1:0] CMD_START_EXP = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START_BIN = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_MEASURE   = 2'd2;

    localparam logic [ACT_BITS-1:0] ACT_APPLY  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_AGAIN  = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_DONE   = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_IGNORE = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_EXP    = 2'd1,
        PH_REMEAS = 2'd2,
        PH_BIN    = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   bias;
        logic   longer;
    } ctrl_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]   command;
        logic [FIELD_CODE-1:0] start_code;
        logic [FIELD_CODE-1:0] end_code;
        logic [OHMS_BITS-1:0]  target_ohms;
        logic                  bias_channel;
        logic                  longer_settle;
        logic [OHMS_BITS-1:0]  measured_ohms;
    } req_t;

    typedef struct packed {
        logic [ACT_BITS-1:0]    action;
        logic [FIELD_CODE-1:0]  dac_code;
        logic [SETTLE_BITS-1:0] settle_ms;
    } rsp_t;

    // Settle wait per channel threshold table, doubled when a longer settle is requested.
    function automatic logic [SETTLE_BITS-1:0] settle_lookup(
        input logic                     bias,
        input logic                     longer,
        input logic [CODE_BITS_MAX-1:0] code
    );
        logic [SETTLE_BITS-1:0] t;
        if (bias) begin
            if (code < 16'd5)         t = 14'd6000;
            else if (code < 16'd20)   t = 14'd5000;
            else if (code < 16'd50)   t = 14'd1500;
            else if (code < 16'd100)  t = 14'd1000;
            else if (code < 16'd1000) t = 14'd750;
            else if (code < 16'd2000) t = 14'd300;
            else if (code < 16'd3000) t = 14'd150;
            else                      t = 14'd125;
        end
        else begin
            if (code < 16'd10)        t = 14'd500;
            else if (code < 16'd20)   t = 14'd250;
            else if (code < 16'd50)   t = 14'd200;
            else if (code < 16'd100)  t = 14'd150;
            else if (code < 16'd500)  t = 14'd140;
            else if (code < 16'd1000) t = 14'd130;
            else if (code < 16'd2000) t = 14'd125;
            else                      t = 14'd100;
        end
        return longer ? (t << 1) : t;
    endfunction

endpackage

// ===== rtl/dces_req_if.sv =====
// Request channel: start and measurement items with valid/ready handshake.
// Depends on dces_pkg for field widths.
interface dces_req_if;
    logic                              valid;
    logic                              ready;
    logic [dces_pkg::CMD_BITS-1:0]     command;
    logic [dces_pkg::FIELD_CODE-1:0]   start_code;
    logic [dces_pkg::FIELD_CODE-1:0]   end_code;
    logic [dces_pkg::OHMS_BITS-1:0]    target_ohms;
    logic                              bias_channel;
    logic                              longer_settle;
    logic [dces_pkg::OHMS_BITS-1:0]    measured_ohms;

    modport source (
        output valid, command, start_code, end_code, target_ohms,
               bias_channel, longer_settle, measured_ohms,
        input  ready
    );

    modport sink (
        input  valid, command, start_code, end_code, target_ohms,
               bias_channel, longer_settle, measured_ohms,
        output ready
    );
endinterface

// ===== rtl/dces_rsp_if.sv =====
// Result channel: action, code and settle time with valid/ready handshake.
// Depends on dces_pkg for field widths.
interface dces_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [dces_pkg::ACT_BITS-1:0]      action;
    logic [dces_pkg::FIELD_CODE-1:0]    dac_code;
    logic [dces_pkg::SETTLE_BITS-1:0]   settle_ms;

    modport source (
        output valid, action, dac_code, settle_ms,
        input  ready
    );

    modport sink (
        input  valid, action, dac_code, settle_ms,
        output ready
    );
endinterface

// ===== rtl/dces_step.sv =====
// Next-state and result logic for one item of the DAC code search.
// Depends on dces_pkg; purely combinational, registered by the top level.
module dces_step #(
    parameter int CODE_BITS = 12
) (
    input  dces_pkg::req_t           item,
    input  dces_pkg::ctrl_t          ctrl_cur,
    input  logic [CODE_BITS:0]       probe_bound_cur,
    input  logic [CODE_BITS:0]       low_pos_cur,
    input  logic [CODE_BITS-1:0]     high_limit_cur,
    input  logic [CODE_BITS-1:0]     probe_code_cur,
    input  logic [CODE_BITS-1:0]     end_bound_cur,
    input  logic [dces_pkg::OHMS_BITS-1:0] goal_ohms_cur,
    output dces_pkg::ctrl_t          ctrl_next,
    output logic [CODE_BITS:0]       probe_bound_next,
    output logic [CODE_BITS:0]       low_pos_next,
    output logic [CODE_BITS-1:0]     high_limit_next,
    output logic [CODE_BITS-1:0]     probe_code_next,
    output logic [CODE_BITS-1:0]     end_bound_next,
    output logic [dces_pkg::OHMS_BITS-1:0] goal_ohms_next,
    output dces_pkg::rsp_t           result
);

    localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

    typedef enum logic [2:0] {
        ADV_IGNORE,
        ADV_EXP,
        ADV_BIN,
        ADV_AGAIN,
        ADV_DONE,
        ADV_APPLY
    } adv_t;

    always_comb
    begin
        adv_t                 adv;
        logic [CODE_BITS-1:0] start_cb;
        logic [CODE_BITS:0]   fin_raw;
        logic [CODE_BITS:0]   mid;
        logic [CODE_BITS-1:0] fin_code;
        logic [CODE_BITS-1:0] ap;
        logic                 above;
        logic                 equal;

        ctrl_next        = ctrl_cur;
        probe_bound_next = probe_bound_cur;
        low_pos_next     = low_pos_cur;
        high_limit_next  = high_limit_cur;
        probe_code_next  = probe_code_cur;
        end_bound_next   = end_bound_cur;
        goal_ohms_next   = goal_ohms_cur;
        adv              = ADV_IGNORE;
        fin_raw          = '0;
        mid              = '0;
        ap               = '0;
        start_cb         = CODE_BITS'(item.start_code);
        above            = item.measured_ohms > goal_ohms_cur;
        equal            = item.measured_ohms == goal_ohms_cur;

        case (item.command)
            dces_pkg::CMD_START_EXP,
            dces_pkg::CMD_START_BIN:
            begin
                end_bound_next   = CODE_BITS'(item.end_code);
                goal_ohms_next   = item.target_ohms;
                ctrl_next.bias   = item.bias_channel;
                ctrl_next.longer = item.longer_settle;
                if (item.command == dces_pkg::CMD_START_EXP)
                begin
                    probe_bound_next = {1'b0, start_cb};
                    adv              = ADV_EXP;
                end
                else
                begin
                    low_pos_next    = {1'b0, start_cb};
                    high_limit_next = CODE_BITS'(item.end_code);
                    adv             = ADV_BIN;
                end
            end
            dces_pkg::CMD_MEASURE:
            begin
                case (ctrl_cur.phase)
                    dces_pkg::PH_EXP:
                    begin
                        if (above)
                        begin
                            probe_bound_next = (probe_bound_cur == '0) ?
                                (CODE_BITS+1)'(1) : (probe_bound_cur << 1);
                            adv = ADV_EXP;
                        end
                        else
                            adv = ADV_AGAIN;
                    end
                    dces_pkg::PH_REMEAS:
                    begin
                        if (equal)
                        begin
                            fin_raw = probe_bound_cur;
                            adv     = ADV_DONE;
                        end
                        else
                        begin
                            low_pos_next    = probe_bound_cur >> 1;
                            high_limit_next = (probe_bound_cur > {1'b0, CODE_MAX}) ?
                                CODE_MAX : probe_bound_cur[CODE_BITS-1:0];
                            adv = ADV_BIN;
                        end
                    end
                    dces_pkg::PH_BIN:
                    begin
                        if (above)
                        begin
                            low_pos_next = {1'b0, probe_code_cur} + (CODE_BITS+1)'(1);
                            adv          = ADV_BIN;
                        end
                        else if (equal)
                        begin
                            fin_raw = {1'b0, probe_code_cur};
                            adv     = ADV_DONE;
                        end
                        else
                        begin
                            high_limit_next = probe_code_cur;
                            adv             = ADV_BIN;
                        end
                    end
                    default:
                        adv = ADV_IGNORE;
                endcase
            end
            default:
                adv = ADV_IGNORE;
        endcase

        // Resolve the advance step: probe, re-measure or finish.
        if (adv == ADV_EXP)
        begin
            if (probe_bound_next < {1'b0, end_bound_next})
            begin
                ap              = probe_bound_next[CODE_BITS-1:0];
                ctrl_next.phase = dces_pkg::PH_EXP;
                adv             = ADV_APPLY;
            end
            else
                adv = ADV_AGAIN;
        end
        else if (adv == ADV_BIN)
        begin
            if (low_pos_next < {1'b0, high_limit_next})
            begin
                mid = low_pos_next +
                      (({1'b0, high_limit_next} - low_pos_next) >> 1);
                ap              = mid[CODE_BITS-1:0];
                ctrl_next.phase = dces_pkg::PH_BIN;
                adv             = ADV_APPLY;
            end
            else
            begin
                fin_raw = (low_pos_next != '0) ?
                          (low_pos_next - (CODE_BITS+1)'(1)) : low_pos_next;
                adv     = ADV_DONE;
            end
        end

        fin_code = (fin_raw > {1'b0, CODE_MAX}) ? CODE_MAX : fin_raw[CODE_BITS-1:0];

        case (adv)
            ADV_APPLY:
            begin
                probe_code_next  = ap;
                result.action    = dces_pkg::ACT_APPLY;
                result.dac_code  = dces_pkg::FIELD_CODE'(ap);
                result.settle_ms = dces_pkg::settle_lookup(ctrl_next.bias,
                    ctrl_next.longer, dces_pkg::CODE_BITS_MAX'(ap));
            end
            ADV_AGAIN:
            begin
                ctrl_next.phase  = dces_pkg::PH_REMEAS;
                result.action    = dces_pkg::ACT_AGAIN;
                result.dac_code  = dces_pkg::FIELD_CODE'(probe_code_cur);
                result.settle_ms = '0;
            end
            ADV_DONE:
            begin
                ctrl_next.phase  = dces_pkg::PH_IDLE;
                result.action    = dces_pkg::ACT_DONE;
                result.dac_code  = dces_pkg::FIELD_CODE'(fin_code);
                result.settle_ms = '0;
            end
            default:
            begin
                result.action    = dces_pkg::ACT_IGNORE;
                result.dac_code  = '0;
                result.settle_ms = '0;
            end
        endcase
    end

endmodule

// ===== rtl/dac_code_exponential_search_unit.sv =====
// DAC code search block: usage
// req channel takes start items (exponential or binary search) and
// measurement items; rsp channel gives exactly one result item per request
// item, in order: apply a code and wait settle_ms, measure again, done with
// the found code, or ignored.
// Flow: a request accepted lands in the input register; when it moves on,
// the search state and the result register update together, and the result
// is valid from then until it is taken.
// Throughput: one item per cycle while rsp is not held off; each item is one
// compare against the target plus one bound update in a single step stage
// between the input register and the result register.
// Stall: while rsp is held off, the result register keeps its item and the
// input register takes one more request; req.ready then drops until the
// result is taken.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// search to idle with all bounds, codes and the target at zero.
// Depends on dces_pkg, dces_req_if, dces_rsp_if, dces_step, assert_macros.svh.
`include "assert_macros.svh"

module dac_code_exponential_search_unit #(
    parameter int CODE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    dces_req_if.sink    req,
    dces_rsp_if.source  rsp
);

    logic                              req_valid_reg;
    dces_pkg::req_t                    req_item_reg;
    logic                              rsp_valid_reg;
    dces_pkg::rsp_t                    rsp_item_reg;
    logic                              advance;

    dces_pkg::ctrl_t                   ctrl_reg;
    dces_pkg::ctrl_t                   ctrl_next;
    logic [CODE_BITS:0]                probe_bound_reg;
    logic [CODE_BITS:0]                probe_bound_next;
    logic [CODE_BITS:0]                low_pos_reg;
    logic [CODE_BITS:0]                low_pos_next;
    logic [CODE_BITS-1:0]              high_limit_reg;
    logic [CODE_BITS-1:0]              high_limit_next;
    logic [CODE_BITS-1:0]              probe_code_reg;
    logic [CODE_BITS-1:0]              probe_code_next;
    logic [CODE_BITS-1:0]              end_bound_reg;
    logic [CODE_BITS-1:0]              end_bound_next;
    logic [dces_pkg::OHMS_BITS-1:0]    goal_ohms_reg;
    logic [dces_pkg::OHMS_BITS-1:0]    goal_ohms_next;
    dces_pkg::rsp_t                    rsp_next;

    assign advance   = req_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !req_valid_reg || advance;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.action    = rsp_item_reg.action;
    assign rsp.dac_code  = rsp_item_reg.dac_code;
    assign rsp.settle_ms = rsp_item_reg.settle_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                req_valid_reg <= req.valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_item_reg.command       <= req.command;
            req_item_reg.start_code    <= req.start_code;
            req_item_reg.end_code      <= req.end_code;
            req_item_reg.target_ohms   <= req.target_ohms;
            req_item_reg.bias_channel  <= req.bias_channel;
            req_item_reg.longer_settle <= req.longer_settle;
            req_item_reg.measured_ohms <= req.measured_ohms;
        end
        if (advance)
            rsp_item_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg        <= '{phase: dces_pkg::PH_IDLE, bias: 1'b0, longer: 1'b0};
            probe_bound_reg <= '0;
            low_pos_reg     <= '0;
            high_limit_reg  <= '0;
            probe_code_reg  <= '0;
            end_bound_reg   <= '0;
            goal_ohms_reg   <= '0;
        end
        else if (advance)
        begin
            ctrl_reg        <= ctrl_next;
            probe_bound_reg <= probe_bound_next;
            low_pos_reg     <= low_pos_next;
            high_limit_reg  <= high_limit_next;
            probe_code_reg  <= probe_code_next;
            end_bound_reg   <= end_bound_next;
            goal_ohms_reg   <= goal_ohms_next;
        end
    end

    dces_step #(
        .CODE_BITS (CODE_BITS)
    ) u_step (
        .item             (req_item_reg),
        .ctrl_cur         (ctrl_reg),
        .probe_bound_cur  (probe_bound_reg),
        .low_pos_cur      (low_pos_reg),
        .high_limit_cur   (high_limit_reg),
        .probe_code_cur   (probe_code_reg),
        .end_bound_cur    (end_bound_reg),
        .goal_ohms_cur    (goal_ohms_reg),
        .ctrl_next        (ctrl_next),
        .probe_bound_next (probe_bound_next),
        .low_pos_next     (low_pos_next),
        .high_limit_next  (high_limit_next),
        .probe_code_next  (probe_code_next),
        .end_bound_next   (end_bound_next),
        .goal_ohms_next   (goal_ohms_next),
        .result           (rsp_next)
    );

    // Doubling only continues below the end bound, so the bound cannot wrap.
    `DCES_ASSERT(a_exp_below_end, clk, rst_n,
        ctrl_reg.phase != dces_pkg::PH_EXP || probe_bound_reg < {1'b0, end_bound_reg},
        "exponential probe bound not below end bound")
    // A binary probe is only pending over a non-empty interval.
    `DCES_ASSERT(a_bin_interval, clk, rst_n,
        ctrl_reg.phase != dces_pkg::PH_BIN || low_pos_reg < {1'b0, high_limit_reg},
        "binary search pending over empty interval")
    `DCES_ASSERT_NEXT(a_done_idles, clk, rst_n,
        advance && rsp_next.action == dces_pkg::ACT_DONE,
        ctrl_reg.phase == dces_pkg::PH_IDLE,
        "search not idle after done result")
    `DCES_ASSERT(a_quiet_settle, clk, rst_n,
        !rsp_valid_reg || rsp_item_reg.action == dces_pkg::ACT_APPLY ||
        rsp_item_reg.settle_ms == '0,
        "settle time on a result that applies no code")
    `DCES_ASSERT(a_ready_when_free, clk, rst_n,
        rsp_valid_reg || req.ready,
        "request stalled with result register empty")

endmodule

// ===== dv/testbench.sv =====
// Regression bench for dac_code_exponential_search_unit: feeds start and measurement
// items, predicts every result in order and checks it against the result channel.
// Depends on dces_pkg, dces_req_if, dces_rsp_if and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                            CLK_HALF       = 5;
    localparam int unsigned                   LIMIT_CYCLES   = 400000;
    localparam int unsigned                   ITEM_TARGET    = 1100;
    localparam int unsigned                   NO_IDLE_ITEMS  = 250;
    localparam int unsigned                   REPORT_MAX     = 10;
    localparam int                            HOLD_OFF       = 60;
    localparam int                            TAIL_CYCLES    = 4;
    localparam logic [12:0]                   CODE_TOP       = 13'd4095;
    localparam logic [dces_pkg::OHMS_BITS-1:0] OHMS_RANGE_TOP = 24'd10_000_000;
    localparam logic [dces_pkg::OHMS_BITS-1:0] OHMS_ALL_ONES  = 24'hFF_FFFF;
    localparam logic [dces_pkg::CMD_BITS-1:0]  CMD_UNUSED     = 2'd3;

    logic clk;
    logic rst_n;

    dces_req_if req ();
    dces_rsp_if rsp ();

    dac_code_exponential_search_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // search state tracked alongside the block
    dces_pkg::phase_t                  srch_phase;
    logic [12:0]                       exp_bound;
    logic [12:0]                       bin_low;
    logic [12:0]                       bin_high;
    logic [dces_pkg::FIELD_CODE-1:0]   applied_code;
    logic [dces_pkg::OHMS_BITS-1:0]    goal_ohms_q;
    logic [dces_pkg::FIELD_CODE-1:0]   end_code_q;
    logic                              bias_sel;
    logic                              longer_sel;

    dces_pkg::rsp_t pending_results[$];
    dces_pkg::rsp_t latest_result;
    int unsigned    search_items;
    int unsigned    fail_count;
    int unsigned    cycle_count;
    bit             sender_gaps;
    bit             receiver_gaps;
    int             hold_cycles;
    int unsigned    hold_requests;
    int unsigned    hold_served;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic logic [dces_pkg::SETTLE_BITS-1:0] settle_for(
        input logic [dces_pkg::FIELD_CODE-1:0] code
    );
        logic [dces_pkg::SETTLE_BITS-1:0] wait_ms;
        if (bias_sel)
        begin
            if (code < 12'd5)         wait_ms = 14'd6000;
            else if (code < 12'd20)   wait_ms = 14'd5000;
            else if (code < 12'd50)   wait_ms = 14'd1500;
            else if (code < 12'd100)  wait_ms = 14'd1000;
            else if (code < 12'd1000) wait_ms = 14'd750;
            else if (code < 12'd2000) wait_ms = 14'd300;
            else if (code < 12'd3000) wait_ms = 14'd150;
            else                      wait_ms = 14'd125;
        end
        else
        begin
            if (code < 12'd10)        wait_ms = 14'd500;
            else if (code < 12'd20)   wait_ms = 14'd250;
            else if (code < 12'd50)   wait_ms = 14'd200;
            else if (code < 12'd100)  wait_ms = 14'd150;
            else if (code < 12'd500)  wait_ms = 14'd140;
            else if (code < 12'd1000) wait_ms = 14'd130;
            else if (code < 12'd2000) wait_ms = 14'd125;
            else                      wait_ms = 14'd100;
        end
        return longer_sel ? (wait_ms << 1) : wait_ms;
    endfunction

    function automatic dces_pkg::rsp_t probe_at(input logic [12:0] code);
        applied_code = code[dces_pkg::FIELD_CODE-1:0];
        return '{dces_pkg::ACT_APPLY, applied_code, settle_for(applied_code)};
    endfunction

    function automatic dces_pkg::rsp_t conclude(input logic [12:0] code);
        srch_phase = dces_pkg::PH_IDLE;
        return '{dces_pkg::ACT_DONE,
                 (code > CODE_TOP) ? CODE_TOP[dces_pkg::FIELD_CODE-1:0]
                                   : code[dces_pkg::FIELD_CODE-1:0],
                 14'd0};
    endfunction

    function automatic dces_pkg::rsp_t measure_again();
        srch_phase = dces_pkg::PH_REMEAS;
        return '{dces_pkg::ACT_AGAIN, applied_code, 14'd0};
    endfunction

    function automatic dces_pkg::rsp_t exp_next();
        if (exp_bound < {1'b0, end_code_q})
        begin
            srch_phase = dces_pkg::PH_EXP;
            return probe_at(exp_bound);
        end
        return measure_again();
    endfunction

    function automatic dces_pkg::rsp_t bin_next();
        if (bin_low < bin_high)
        begin
            srch_phase = dces_pkg::PH_BIN;
            return probe_at(bin_low + ((bin_high - bin_low) >> 1));
        end
        return conclude((bin_low != 13'd0) ? bin_low - 13'd1 : bin_low);
    endfunction

    function automatic dces_pkg::rsp_t predict_result(input dces_pkg::req_t item);
        dces_pkg::rsp_t ignored;
        ignored = '{dces_pkg::ACT_IGNORE, 12'd0, 14'd0};
        case (item.command)
            dces_pkg::CMD_START_EXP, dces_pkg::CMD_START_BIN:
            begin
                // a start always drops whatever search was running
                end_code_q  = item.end_code;
                goal_ohms_q = item.target_ohms;
                bias_sel    = item.bias_channel;
                longer_sel  = item.longer_settle;
                if (item.command == dces_pkg::CMD_START_EXP)
                begin
                    exp_bound = {1'b0, item.start_code};
                    return exp_next();
                end
                bin_low  = {1'b0, item.start_code};
                bin_high = {1'b0, item.end_code};
                return bin_next();
            end
            dces_pkg::CMD_MEASURE:
            begin
                case (srch_phase)
                    dces_pkg::PH_IDLE: return ignored;
                    dces_pkg::PH_EXP:
                    begin
                        if (item.measured_ohms > goal_ohms_q)
                        begin
                            exp_bound = (exp_bound == 13'd0) ? 13'd1 : exp_bound << 1;
                            return exp_next();
                        end
                        return measure_again();
                    end
                    dces_pkg::PH_REMEAS:
                    begin
                        if (item.measured_ohms == goal_ohms_q)
                            return conclude(exp_bound);
                        // bisect the last doubling interval, clipped to the code range
                        bin_low  = exp_bound >> 1;
                        bin_high = (exp_bound > CODE_TOP) ? CODE_TOP : exp_bound;
                        return bin_next();
                    end
                    default:
                    begin
                        if (item.measured_ohms > goal_ohms_q)
                        begin
                            bin_low = {1'b0, applied_code} + 13'd1;
                            return bin_next();
                        end
                        if (item.measured_ohms == goal_ohms_q)
                            return conclude({1'b0, applied_code});
                        bin_high = {1'b0, applied_code};
                        return bin_next();
                    end
                endcase
            end
            default: return ignored;
        endcase
    endfunction

    // ---------------------------------------------------------------- items

    function automatic dces_pkg::req_t random_item();
        dces_pkg::req_t item;
        item.command       = 2'($urandom_range(3));
        item.start_code    = 12'($urandom);
        item.end_code      = 12'($urandom);
        item.target_ohms   = 24'($urandom);
        item.bias_channel  = 1'($urandom_range(1));
        item.longer_settle = 1'($urandom_range(1));
        item.measured_ohms = 24'($urandom);
        return item;
    endfunction

    function automatic dces_pkg::req_t start_item(
        input logic [dces_pkg::CMD_BITS-1:0]   cmd,
        input logic [dces_pkg::FIELD_CODE-1:0] first_code,
        input logic [dces_pkg::FIELD_CODE-1:0] bound_code,
        input logic [dces_pkg::OHMS_BITS-1:0]  goal,
        input logic                            bias,
        input logic                            longer
    );
        dces_pkg::req_t item;
        item               = random_item();
        item.command       = cmd;
        item.start_code    = first_code;
        item.end_code      = bound_code;
        item.target_ohms   = goal;
        item.bias_channel  = bias;
        item.longer_settle = longer;
        return item;
    endfunction

    function automatic dces_pkg::req_t measure_item(
        input logic [dces_pkg::OHMS_BITS-1:0] ohms
    );
        dces_pkg::req_t item;
        item               = random_item();
        item.command       = dces_pkg::CMD_MEASURE;
        item.measured_ohms = ohms;
        return item;
    endfunction

    function automatic dces_pkg::req_t random_start();
        logic [dces_pkg::FIELD_CODE-1:0] first_code;
        logic [dces_pkg::FIELD_CODE-1:0] bound_code;
        logic [dces_pkg::OHMS_BITS-1:0]  goal;
        case ($urandom_range(3))
            0:       first_code = '0;
            1:       first_code = 12'($urandom_range(15));
            2:       first_code = 12'($urandom_range(200));
            default: first_code = 12'($urandom);
        endcase
        // a random bound may land below the start: no probe, or an empty interval
        bound_code = ($urandom_range(9) < 6) ? 12'hFFF : 12'($urandom);
        case ($urandom_range(7))
            0:       goal = '0;
            1:       goal = OHMS_ALL_ONES;
            2:       goal = OHMS_RANGE_TOP;
            default: goal = 24'($urandom_range(OHMS_RANGE_TOP));
        endcase
        return start_item($urandom_range(1) ? dces_pkg::CMD_START_BIN : dces_pkg::CMD_START_EXP,
                          first_code, bound_code, goal,
                          1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    // Resistance falls as the code rises; it crosses the target at the knee code.
    function automatic logic [dces_pkg::OHMS_BITS-1:0] ohms_at(
        input logic [dces_pkg::FIELD_CODE-1:0] code,
        input int unsigned                     knee,
        input logic [dces_pkg::OHMS_BITS-1:0]  goal,
        input bit                              exact_hits
    );
        int unsigned delta;
        int unsigned sum;
        delta = ($urandom_range(9) == 0) ? $urandom_range(OHMS_ALL_ONES)
                                         : $urandom_range(40000, 1);
        sum   = 32'(goal) + delta;
        if (32'(code) == knee && exact_hits)
            return goal;
        if (32'(code) < knee)
            return (sum > 32'(OHMS_ALL_ONES)) ? OHMS_ALL_ONES
                                              : sum[dces_pkg::OHMS_BITS-1:0];
        return (32'(goal) < delta) ? '0 : goal - delta[dces_pkg::OHMS_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------- sender

    task automatic send_item(input dces_pkg::req_t item);
        while (sender_gaps && $urandom_range(99) < 26)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.command       <= item.command;
        req.start_code    <= item.start_code;
        req.end_code      <= item.end_code;
        req.target_ohms   <= item.target_ohms;
        req.bias_channel  <= item.bias_channel;
        req.longer_settle <= item.longer_settle;
        req.measured_ohms <= item.measured_ohms;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        latest_result = predict_result(item);
        pending_results.push_back(latest_result);
        if (latest_result.action != dces_pkg::ACT_IGNORE)
            search_items++;
    endtask

    // Stops offering and waits until every predicted result has been checked.
    task automatic wait_for_results();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Answers every probe from a knee model; may cut in with a new start,
    // a stray item, or a measurement after the search is done.
    task automatic run_search(input dces_pkg::req_t opener, input int unsigned knee,
                              input bit exact_hits, input bit may_break);
        dces_pkg::rsp_t step;
        int             probes;
        send_item(opener);
        step   = latest_result;
        probes = 0;
        while ((step.action == dces_pkg::ACT_APPLY || step.action == dces_pkg::ACT_AGAIN) &&
               probes < 40)
        begin
            if (may_break && $urandom_range(99) < 3)
                return;
            if (may_break && $urandom_range(99) < 4)
                send_item(start_item(CMD_UNUSED, 12'($urandom), 12'($urandom),
                                     24'($urandom), 1'b1, 1'b0));
            send_item(measure_item(ohms_at(step.dac_code, knee, opener.target_ohms,
                                           exact_hits)));
            step = latest_result;
            probes++;
        end
        if (may_break && $urandom_range(99) < 10)
            send_item(measure_item(24'($urandom)));
    endtask

    // ---------------------------------------------------------------- receiver / checker

    function automatic void log_failure(input string what);
        if (fail_count < REPORT_MAX)
            $display("[%0t] MISMATCH %s", $time, what);
        fail_count++;
    endfunction

    task automatic check_result();
        dces_pkg::rsp_t want;
        if (pending_results.size() == 0)
        begin
            log_failure($sformatf("unexpected result: action %0d code %0d settle %0d",
                                  rsp.action, rsp.dac_code, rsp.settle_ms));
            return;
        end
        want = pending_results.pop_front();
        if (rsp.action !== want.action || rsp.dac_code !== want.dac_code ||
            rsp.settle_ms !== want.settle_ms)
            log_failure($sformatf("expected action %0d code %0d settle %0d, got %0d %0d %0d",
                                  want.action, want.dac_code, want.settle_ms,
                                  rsp.action, rsp.dac_code, rsp.settle_ms));
    endtask

    initial
    begin
        rsp.ready   <= 1'b0;
        hold_cycles <= 0;
        hold_served <= 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
                check_result();
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_cycles <= HOLD_OFF;
                rsp.ready   <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                rsp.ready   <= 1'b0;
            end
            else
            begin
                rsp.ready <= !(receiver_gaps && $urandom_range(99) < 26);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] timeout, %0d results outstanding", $time, pending_results.size());
        $display("dac_code_exponential_search_unit regression: fail");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_open_cases();
        send_item(measure_item(24'd1234));                              // idle measurement
        send_item(start_item(CMD_UNUSED, 12'd5, 12'd6, 24'd7, 1'b0, 1'b0));
        send_item(start_item(dces_pkg::CMD_START_EXP, 12'hFFF, 12'd0, 24'd0, 1'b1, 1'b1));
        send_item(measure_item(24'd0));
        send_item(start_item(dces_pkg::CMD_START_BIN, 12'd100, 12'd100, 24'd500, 1'b0, 1'b0));
        send_item(start_item(dces_pkg::CMD_START_BIN, 12'd0, 12'd0, 24'd500, 1'b1, 1'b0));
        // exact hit once the doubled bound has passed the end: code saturates
        send_item(start_item(dces_pkg::CMD_START_EXP, 12'd3000, 12'hFFF, 24'd5_000_000,
                             1'b0, 1'b0));
        send_item(measure_item(OHMS_ALL_ONES));
        send_item(measure_item(24'd5_000_000));
        send_item(start_item(dces_pkg::CMD_START_EXP, 12'd0, 12'hFFF, OHMS_RANGE_TOP,
                             1'b1, 1'b0));
        send_item(measure_item(OHMS_RANGE_TOP + 24'd1));
        send_item(measure_item(OHMS_RANGE_TOP));
        send_item(measure_item(24'd0));
        // restart while a search is still running, by now in its binary phase
        send_item(start_item(dces_pkg::CMD_START_BIN, 12'd0, 12'hFFF, OHMS_ALL_ONES,
                             1'b0, 1'b1));
        send_item(measure_item(24'd0));
        send_item(measure_item(OHMS_ALL_ONES));
        send_item(measure_item(24'd7));
        send_item(dces_pkg::req_t'('1));
        send_item(start_item(dces_pkg::CMD_START_EXP, 12'hFFF, 12'hFFF, 24'd0, 1'b1, 1'b1));
        send_item(measure_item(24'd1));
        send_item(measure_item(24'd0));
        send_item(dces_pkg::req_t'('0));
        send_item(measure_item(OHMS_ALL_ONES));
        wait_for_results();
    endtask

    task automatic test_random_searches(input int unsigned item_goal);
        int unsigned knee;
        while (search_items < item_goal)
        begin
            knee = $urandom_range(1) ? $urandom_range(64) : $urandom_range(4096);
            if ($urandom_range(99) < 88)
                run_search(random_start(), knee, 1'($urandom_range(1)), 1'b1);
            else
                send_item(random_item());
        end
    endtask

    task automatic test_backpressure();
        int n;
        hold_requests++;
        // sender keeps offering through the hold-off until the block backs up
        for (n = 0; n < 3; n++)
            run_search(random_start(), $urandom_range(4096), 1'b1, 1'b0);
        // sender pauses until the block has drained completely
        wait_for_results();
    endtask

    task automatic test_no_idle();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        test_random_searches(search_items + NO_IDLE_ITEMS);
        wait_for_results();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        req.valid         <= 1'b0;
        req.command       <= '0;
        req.start_code    <= '0;
        req.end_code      <= '0;
        req.target_ohms   <= '0;
        req.bias_channel  <= 1'b0;
        req.longer_settle <= 1'b0;
        req.measured_ohms <= '0;
        srch_phase        = dces_pkg::PH_IDLE;
        exp_bound         = '0;
        bin_low           = '0;
        bin_high          = '0;
        applied_code      = '0;
        goal_ohms_q       = '0;
        end_code_q        = '0;
        bias_sel          = 1'b0;
        longer_sel        = 1'b0;
        search_items      = 0;
        fail_count        = 0;
        hold_requests     = 0;
        sender_gaps       = 1'b1;
        receiver_gaps     = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_open_cases();
        test_backpressure();
        test_no_idle();
        test_random_searches(ITEM_TARGET);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("dac_code_exponential_search_unit regression: pass");
        else
            $display("dac_code_exponential_search_unit regression: fail");
        $finish;
    end

endmodule
